[rtl/core/ssort_pkg.sv]
// Shared constants for the shell sort core: default sizes and stream widths.
// No dependencies; imported by the core, the comparator and the port checker.
package ssort_pkg;

    localparam int MAX_ELEMENTS_DEF = 64;
    localparam int KEY_WIDTH_DEF    = 32;

    // Stream payload widths (fixed by the key field width).
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 32;
    localparam int OUT_TUSER_W = 1;

endpackage

[rtl/core/ssort_ram.sv]
// Generic simple dual-port RAM: one write port, two registered read ports.
// Standalone; no package dependencies.
module ssort_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

[rtl/core/ssort_cmp.sv]
// Key comparator: greater-than, unsigned or two's complement.
// Depends on ssort_pkg for the default key width.
module ssort_cmp import ssort_pkg::*; #(
    parameter int KEY_WIDTH = KEY_WIDTH_DEF
) (
    input  logic [KEY_WIDTH-1:0] i_a,
    input  logic [KEY_WIDTH-1:0] i_b,
    input  logic                 i_signed,
    output logic                 o_gt
);

    logic [KEY_WIDTH-1:0] w_flip;

    // Flipping the sign bit turns a two's complement order into an unsigned one.
    assign w_flip = KEY_WIDTH'(i_signed) << (KEY_WIDTH - 1);
    assign o_gt   = (i_a ^ w_flip) > (i_b ^ w_flip);

endmodule

[rtl/core/shell_sort_halving_gaps_core.sv]
// Load: one key per cycle. Sort: a gap-insertion compare is a RAM read, then a compare;
// an exchange adds a write step, an outer index an index check, a gap a gap check and a
// pass exit; a last gap check ends it. Emit per key: RAM read, load, transfer to the sink.
// The input is not ready from the last key of a run until the last result is taken.
// Synchronous active-low reset clears control state and the signed-keys register;
// buffer contents are not cleared and are only read after being written in a run.
module shell_sort_halving_gaps_core import ssort_pkg::*; #(
    parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF,
    parameter int KEY_WIDTH    = KEY_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // configuration: bit 0 = signed_keys
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic                   i_cfg_data,
    // key input stream
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [31:0] key
    input  logic                   s_axis_tlast,   // last_in
    // sorted output stream
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [31:0] sorted_key
    output logic                   m_axis_tlast,   // last_out
    output logic [OUT_TUSER_W-1:0] m_axis_tuser    // [0] overflow
);

    localparam int AW    = $clog2(MAX_ELEMENTS);
    localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_GAP,
        ST_OUTER,
        ST_READ,
        ST_CMP,
        ST_WR2,
        ST_EMIT_RD,
        ST_EMIT_LD
    } t_state;

    t_state r_state;
    logic   r_emit_wait;

    logic [CNT_W-1:0]     r_count;
    logic [CNT_W-1:0]     n_count;
    logic                 r_ovf;
    logic                 r_signed;
    logic [AW-1:0]        r_gap;
    logic [CNT_W-1:0]     r_i;
    logic [AW-1:0]        r_j;
    logic [AW-1:0]        r_k;
    logic [KEY_WIDTH-1:0] r_hold;

    logic                   r_m_valid;
    logic [OUT_TDATA_W-1:0] r_m_data;
    logic                   r_m_last;
    logic                   r_m_user;

    logic                 w_in_xfer;
    logic                 w_has_room;
    logic [KEY_WIDTH-1:0] w_key_in;
    logic [OUT_TDATA_W-1:0] w_key_out;

    logic                 w_we;
    logic [AW-1:0]        w_waddr;
    logic [KEY_WIDTH-1:0] w_wdata;
    logic [AW-1:0]        w_raddr_a;
    logic [AW-1:0]        w_raddr_b;
    logic [KEY_WIDTH-1:0] w_rdata_a;
    logic [KEY_WIDTH-1:0] w_rdata_b;
    logic                 w_gt;

    // Key width adaptation between the 32-bit stream field and the stored key.
    generate
        if (KEY_WIDTH > IN_TDATA_W) begin : g_wide
            assign w_key_in  = {{(KEY_WIDTH - IN_TDATA_W){1'b0}}, s_axis_tdata};
            assign w_key_out = w_rdata_a[OUT_TDATA_W-1:0];
        end else if (KEY_WIDTH == IN_TDATA_W) begin : g_equal
            assign w_key_in  = s_axis_tdata;
            assign w_key_out = w_rdata_a;
        end else begin : g_narrow
            assign w_key_in  = s_axis_tdata[KEY_WIDTH-1:0];
            assign w_key_out = {{(OUT_TDATA_W - KEY_WIDTH){1'b0}}, w_rdata_a};
        end
    endgenerate

    assign s_axis_tready = (r_state == ST_LOAD);
    assign w_in_xfer     = s_axis_tvalid && s_axis_tready;
    assign w_has_room    = (r_count < CNT_W'(MAX_ELEMENTS));
    assign n_count       = (w_in_xfer && w_has_room) ? r_count + CNT_W'(1) : r_count;

    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tlast  = r_m_last;
    assign m_axis_tuser  = OUT_TUSER_W'(r_m_user);

    // RAM port steering by sequencer state.
    always_comb begin
        w_we      = 1'b0;
        w_waddr   = r_j;
        w_wdata   = w_rdata_b;
        w_raddr_a = r_j;
        w_raddr_b = r_j + r_gap;
        unique case (r_state)
            ST_LOAD: begin
                w_we    = w_in_xfer && w_has_room;
                w_waddr = r_count[AW-1:0];
                w_wdata = w_key_in;
            end
            ST_CMP: begin
                w_we    = w_gt;
                w_waddr = r_j;
                w_wdata = w_rdata_b;
            end
            ST_WR2: begin
                w_we    = 1'b1;
                w_waddr = r_j + r_gap;
                w_wdata = r_hold;
            end
            ST_EMIT_RD, ST_EMIT_LD: begin
                w_raddr_a = r_k;
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    ssort_ram #(
        .WIDTH (KEY_WIDTH),
        .DEPTH (MAX_ELEMENTS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_waddr   (w_waddr),
        .i_wdata   (w_wdata),
        .i_raddr_a (w_raddr_a),
        .i_raddr_b (w_raddr_b),
        .o_rdata_a (w_rdata_a),
        .o_rdata_b (w_rdata_b)
    );

    ssort_cmp #(
        .KEY_WIDTH (KEY_WIDTH)
    ) u_cmp (
        .i_a      (w_rdata_a),
        .i_b      (w_rdata_b),
        .i_signed (r_signed),
        .o_gt     (w_gt)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_signed <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_signed <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_emit_wait <= 1'b0;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_m_valid   <= 1'b0;
        end else begin
            unique case (r_state)
                ST_LOAD: begin
                    if (w_in_xfer) begin
                        r_count <= n_count;
                        if (!w_has_room) begin
                            r_ovf <= 1'b1;
                        end
                        if (s_axis_tlast) begin
                            r_gap   <= AW'(n_count >> 1);
                            r_state <= ST_GAP;
                        end
                    end
                end
                ST_GAP: begin
                    if (r_gap == '0) begin
                        r_k     <= '0;
                        r_state <= ST_EMIT_RD;
                    end else begin
                        r_i     <= CNT_W'(r_gap);
                        r_state <= ST_OUTER;
                    end
                end
                ST_OUTER: begin
                    if (r_i >= r_count) begin
                        r_gap   <= r_gap >> 1;
                        r_state <= ST_GAP;
                    end else begin
                        r_j     <= AW'(r_i - CNT_W'(r_gap));
                        r_state <= ST_READ;
                    end
                end
                ST_READ: begin
                    r_state <= ST_CMP;
                end
                ST_CMP: begin
                    if (w_gt) begin
                        r_hold  <= w_rdata_a;
                        r_state <= ST_WR2;
                    end else begin
                        r_i     <= r_i + CNT_W'(1);
                        r_state <= ST_OUTER;
                    end
                end
                ST_WR2: begin
                    // step back by one gap while the insertion can continue
                    if (r_j >= r_gap) begin
                        r_j     <= r_j - r_gap;
                        r_state <= ST_READ;
                    end else begin
                        r_i     <= r_i + CNT_W'(1);
                        r_state <= ST_OUTER;
                    end
                end
                ST_EMIT_RD: begin
                    r_state <= ST_EMIT_LD;
                end
                ST_EMIT_LD: begin
                    if (!r_emit_wait) begin
                        r_m_valid   <= 1'b1;
                        r_m_data    <= w_key_out;
                        r_m_last    <= ({1'b0, r_k} + (AW + 1)'(1)) == (AW + 1)'(r_count);
                        r_m_user    <= r_ovf;
                        r_emit_wait <= 1'b1;
                    end else if (m_axis_tready) begin
                        r_m_valid   <= 1'b0;
                        r_emit_wait <= 1'b0;
                        if (r_m_last) begin
                            r_count <= '0;
                            r_ovf   <= 1'b0;
                            r_state <= ST_LOAD;
                        end else begin
                            r_k     <= r_k + AW'(1);
                            r_state <= ST_EMIT_RD;
                        end
                    end
                end
                default: begin
                    r_state <= ST_LOAD;
                end
            endcase
        end
    end

endmodule

[rtl/core/ssort_chk.sv]
// Port-level checker for the shell sort core, bound to the top level.
// Depends on ssort_pkg for stream widths.
module ssort_chk import ssort_pkg::*; (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   s_axis_tvalid,
    input logic                   s_axis_tready,
    input logic                   s_axis_tlast,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input logic                   m_axis_tlast
);

    // Loading and emitting never overlap.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input ready while a result is pending");

    // Reset drops any pending result.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // A stalled result holds its data.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // Last key of a run starts the sort; no result in the following cycle.
    a_sort_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !m_axis_tvalid && !s_axis_tready)
        else $error("no sort phase after last input key");

    // Final result transfer returns the block to loading.
    a_back_to_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && m_axis_tlast |=> s_axis_tready)
        else $error("not ready for a new run after last result");

endmodule

bind shell_sort_halving_gaps_core ssort_chk u_ssort_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
